@@ sv/config_bitstream_frame_parser_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the configuration bitstream frame parser
// Shared forms for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef CONFIG_BITSTREAM_FRAME_PARSER_TOP_ASSERT_SVH
`define CONFIG_BITSTREAM_FRAME_PARSER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define CBFP_ASSERT_NOW(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
    else $error("cbfp assertion failed");

// Check a consequence in the cycle after its cause.
`define CBFP_ASSERT_NEXT(label, clk, rst, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("cbfp assertion failed");

`endif

@@ sv/cbfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbfp_pkg
// Types and constants shared by the bitstream frame parser modules.
// ----------------------------------------------------------------------------
package cbfp_pkg;

  localparam logic [31:0] SYNC_WORD  = 32'hAA995566;
  localparam logic [31:0] NOOP_WORD  = 32'h20000000;
  localparam logic [31:0] FAR_RESET  = 32'hAABBCCDD;
  localparam logic [31:0] CMD_DESYNC = 32'd13;

  localparam logic [2:0] PKT_TYPE1 = 3'd1;
  localparam logic [2:0] PKT_TYPE2 = 3'd2;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  localparam logic [4:0] REG_CRC  = 5'd0;
  localparam logic [4:0] REG_FAR  = 5'd1;
  localparam logic [4:0] REG_FDRI = 5'd2;
  localparam logic [4:0] REG_CMD  = 5'd4;

  typedef enum logic [2:0] {
    EXP_HEADER    = 3'd0,
    EXP_CRC_DATA  = 3'd1,
    EXP_FAR_DATA  = 3'd2,
    EXP_FDRI_HDR  = 3'd3,
    EXP_FDRI_DATA = 3'd4,
    EXP_CMD_DATA  = 3'd5
  } expect_t;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_DONE      = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_NO_FRAMES = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        frame_valid;
    logic [31:0] frame_address;
    logic [19:0] frame_offset;
    logic [26:0] frame_length;
    logic [6:0]  frames_found;
    status_t     status;
    logic        final_res;
  } result_t;

endpackage

@@ sv/cbfp_in_reg.sv @@
// ----------------------------------------------------------------------------
// cbfp_in_reg
// Input register: captures one item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module cbfp_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  cbfp_pkg::item_t item_in,
  input  logic          advance,
  output logic          hold_valid,
  output cbfp_pkg::item_t hold_item
);
  import cbfp_pkg::*;

  logic accept;

  assign item_stall = hold_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= item_in;
    end
  end

endmodule

@@ sv/cbfp_parser.sv @@
// ----------------------------------------------------------------------------
// cbfp_parser
// Packet decoder: parser state and the combinational decode of one word.
// ----------------------------------------------------------------------------
`include "config_bitstream_frame_parser_top_assert.svh"

module cbfp_parser #(
  parameter int MAX_FRAMES = 64,
  parameter int INDEX_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  cbfp_pkg::item_t   item,
  output cbfp_pkg::result_t res
);
  import cbfp_pkg::*;

  localparam int FT_W = $clog2(MAX_FRAMES + 1);
  localparam logic [FT_W-1:0] FT_MAX = FT_W'(MAX_FRAMES);

  logic                  in_sync, in_sync_next;
  logic [31:0]           frame_addr, frame_addr_next;
  expect_t               expect_kind, expect_next;
  logic [26:0]           data_left, data_left_next;
  logic [INDEX_BITS-1:0] word_count, word_count_next;
  logic [FT_W-1:0]       frame_total, frame_total_next;
  status_t               error, error_next;

  logic        type1_write;
  logic        type2_hdr;
  logic [4:0]  reg_addr;
  logic [10:0] cnt11;
  logic [26:0] cnt27;
  logic [26:0] data_dec;
  logic        frame_ok;
  logic        crc_noop;

  assign type1_write = (item.word[31:29] == PKT_TYPE1) && (item.word[28:27] == OP_WRITE);
  assign type2_hdr   = (item.word[31:29] == PKT_TYPE2);
  assign reg_addr    = item.word[17:13];
  assign cnt11       = item.word[10:0];
  assign cnt27       = item.word[26:0];
  assign data_dec    = data_left - 27'd1;
  assign word_count_next = word_count + INDEX_BITS'(1);

  assign frame_ok = (error == ST_RUNNING) && (expect_kind == EXP_FDRI_HDR) && type2_hdr
                    && !(item.last && (cnt27 != '0)) && (frame_total < FT_MAX);
  assign crc_noop = (error == ST_RUNNING)
                    && ((expect_kind == EXP_CRC_DATA)
                        || ((expect_kind == EXP_HEADER) && in_sync && type1_write
                            && (reg_addr == REG_CRC)));

  always_comb begin
    in_sync_next     = in_sync;
    frame_addr_next  = frame_addr;
    expect_next      = expect_kind;
    data_left_next   = data_left;
    frame_total_next = frame_total;
    error_next       = error;
    if (error == ST_RUNNING) begin
      case (expect_kind)
        EXP_CRC_DATA: begin
          expect_next = EXP_HEADER;
        end
        EXP_FAR_DATA: begin
          frame_addr_next = item.word;
          expect_next     = EXP_HEADER;
        end
        EXP_FDRI_HDR: begin
          expect_next = EXP_HEADER;
          if (!type2_hdr) begin
            error_next = ST_MALFORMED;
          end else if (item.last && (cnt27 != '0)) begin
            error_next = ST_TRUNCATED;
          end else if (frame_total >= FT_MAX) begin
            error_next = ST_OVERFLOW;
          end else begin
            frame_total_next = frame_total + FT_W'(1);
            data_left_next   = cnt27;
            expect_next      = (cnt27 != '0) ? EXP_FDRI_DATA : EXP_HEADER;
          end
        end
        EXP_FDRI_DATA: begin
          data_left_next = data_dec;
          if (data_dec == '0) begin
            expect_next = EXP_HEADER;
          end
        end
        EXP_CMD_DATA: begin
          if (item.word == CMD_DESYNC) begin
            in_sync_next = 1'b0;
          end
          expect_next = EXP_HEADER;
        end
        default: begin
          expect_next = EXP_HEADER;
          if (!in_sync) begin
            if (item.word == SYNC_WORD) begin
              in_sync_next = 1'b1;
            end
          end else if (type1_write) begin
            case (reg_addr)
              REG_CRC: begin
                if (cnt11 != 11'd1) error_next = ST_MALFORMED;
                else expect_next = EXP_CRC_DATA;
              end
              REG_FAR: begin
                if (cnt11 != 11'd1) error_next = ST_MALFORMED;
                else expect_next = EXP_FAR_DATA;
              end
              REG_FDRI: begin
                if (cnt11 != 11'd0) error_next = ST_MALFORMED;
                else expect_next = EXP_FDRI_HDR;
              end
              REG_CMD: begin
                if (cnt11 != 11'd1) error_next = ST_MALFORMED;
                else expect_next = EXP_CMD_DATA;
              end
              default: begin
              end
            endcase
          end
        end
      endcase
      if ((error_next == ST_RUNNING) && item.last) begin
        if (expect_next != EXP_HEADER) begin
          error_next = ST_TRUNCATED;
        end else if (frame_total_next == '0) begin
          error_next = ST_NO_FRAMES;
        end
      end
    end
  end

  always_comb begin
    res.out_word      = crc_noop ? NOOP_WORD : item.word;
    res.frame_valid   = frame_ok;
    res.frame_address = frame_ok ? frame_addr : 32'd0;
    res.frame_offset  = frame_ok ? 20'(word_count_next) : 20'd0;
    res.frame_length  = frame_ok ? cnt27 : 27'd0;
    res.frames_found  = 7'(frame_total_next);
    res.final_res     = item.last;
    if (error_next != ST_RUNNING) begin
      res.status = error_next;
    end else begin
      res.status = item.last ? ST_DONE : ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sync     <= 1'b0;
      frame_addr  <= FAR_RESET;
      expect_kind <= EXP_HEADER;
      data_left   <= '0;
      word_count  <= '0;
      frame_total <= '0;
      error       <= ST_RUNNING;
    end else if (advance) begin
      in_sync     <= in_sync_next;
      frame_addr  <= frame_addr_next;
      expect_kind <= expect_next;
      data_left   <= data_left_next;
      word_count  <= word_count_next;
      frame_total <= frame_total_next;
      error       <= error_next;
    end
  end

  `CBFP_ASSERT_NEXT(a_error_sticky, clk, rst, error != ST_RUNNING, error == $past(error))
  `CBFP_ASSERT_NEXT(a_sync_frozen, clk, rst, error != ST_RUNNING, $stable(in_sync))
  `CBFP_ASSERT_NOW(a_frame_bound, clk, rst, 1'b1, frame_total <= FT_MAX)
  `CBFP_ASSERT_NOW(a_frame_no_error, clk, rst, advance && res.frame_valid,
                   res.status == ST_RUNNING || res.status == ST_DONE)

endmodule

@@ sv/cbfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// cbfp_out_reg
// Result register: holds one result item until downstream takes it.
// ----------------------------------------------------------------------------
module cbfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              ready,
  input  cbfp_pkg::result_t res_in,
  output logic              res_valid,
  input  logic              res_stall,
  output cbfp_pkg::result_t res_out
);
  import cbfp_pkg::*;

  logic load;

  assign ready = !res_valid || !res_stall;
  assign load  = load_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready) begin
      res_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ sv/config_bitstream_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// config_bitstream_frame_parser_top
// Parses a configuration bitstream one 32-bit word per item: hunts for sync,
// decodes type-1 writes, replaces CRC writes with NOOP, reports each frame
// data block with its address, offset and length, and keeps a sticky error
// status. Throughput is one item per cycle while res_stall is low; an input
// passes the input register and then the result register. The rate is set
// by the combinational decode between the input register and the result
// register, which also updates the parser state for every word.
// ----------------------------------------------------------------------------
module config_bitstream_frame_parser_top #(
  parameter int MAX_FRAMES = 64,
  parameter int INDEX_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] word,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [31:0] out_word,
  output logic        frame_valid,
  output logic [31:0] frame_address,
  output logic [19:0] frame_offset,
  output logic [26:0] frame_length,
  output logic [6:0]  frames_found,
  output logic [2:0]  status,
  output logic        final_res
);
  import cbfp_pkg::*;

  item_t   item_in;
  item_t   hold_item;
  logic    hold_valid;
  logic    out_ready;
  logic    advance;
  result_t res_next;
  result_t res_out;

  assign item_in.word = word;
  assign item_in.last = last;
  assign advance      = hold_valid && out_ready;

  cbfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  cbfp_parser #(
    .MAX_FRAMES (MAX_FRAMES),
    .INDEX_BITS (INDEX_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .res     (res_next)
  );

  cbfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (hold_valid),
    .ready      (out_ready),
    .res_in     (res_next),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_out    (res_out)
  );

  assign out_word      = res_out.out_word;
  assign frame_valid   = res_out.frame_valid;
  assign frame_address = res_out.frame_address;
  assign frame_offset  = res_out.frame_offset;
  assign frame_length  = res_out.frame_length;
  assign frames_found  = res_out.frames_found;
  assign status        = res_out.status;
  assign final_res     = res_out.final_res;

endmodule
